// ===== rtl/kked_pkg.sv =====
// Shared types and constants for the keypad key event detector.
`timescale 1ns / 1ps

package kked_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int CODE_W  = 8;
    localparam int POS_W   = 2;
    localparam int CNT_W   = 3;
    localparam int CFG_W   = 16;
    localparam int MASK_W  = 4;
    localparam int KIND_W  = 2;

    // Stream payload widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register reset values
    localparam logic [CFG_W-1:0]  DEBOUNCE_RST  = 16'd20;
    localparam logic [CFG_W-1:0]  CLICK_MIN_RST = 16'd20;
    localparam logic [CFG_W-1:0]  CLICK_MAX_RST = 16'd300;
    localparam logic [CFG_W-1:0]  GAP_RST       = 16'd400;
    localparam logic [CFG_W-1:0]  KEEPALIVE_RST = 16'd1000;
    localparam logic [CNT_W-1:0]  MAX_CLICKS_RST = 3'd3;
    localparam logic [MASK_W-1:0] NO_ROWS_RST   = 4'hF;

    typedef enum logic [KIND_W-1:0] {
        EV_PRESSED  = 2'd0,
        EV_RELEASED = 2'd1,
        EV_HOLD     = 2'd2,
        EV_CLICKED  = 2'd3
    } event_kind_t;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_CLICK_MIN  = 3'd1,
        REG_CLICK_MAX  = 3'd2,
        REG_GAP        = 3'd3,
        REG_KEEPALIVE  = 3'd4,
        REG_MAX_CLICKS = 3'd5,
        REG_NO_ROWS    = 3'd6
    } reg_idx_t;

    typedef enum logic {
        BK_READ,
        BK_EVAL
    } bk_phase_t;

    typedef struct packed {
        logic [CFG_W-1:0]  debounce;
        logic [CFG_W-1:0]  click_min;
        logic [CFG_W-1:0]  click_max;
        logic [CFG_W-1:0]  gap;
        logic [CFG_W-1:0]  keepalive;
        logic [CNT_W-1:0]  max_clicks;
        logic [MASK_W-1:0] no_rows;
    } kked_cfg_t;

    // One classified sample on its way from front to back
    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              level;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] now;
    } kked_item_t;

endpackage

// ===== rtl/keypad_key_event_detector.sv =====
// Top level: configuration registers, front end, queue and state engine.
`timescale 1ns / 1ps

// Keypad key event detector. Each s_ transfer carries one sampled key
// (row, column, raw level, key code, millisecond time); each m_ transfer
// carries one event (press, release, hold or click) with the key code and
// click count. The front end takes one sample per cycle, while the two-entry
// queue has room, into that queue and drops positions off the keypad there;
// the state engine handles each on-keypad sample with a state read and time
// differences, then a compare and write-back of the per-key state, and takes
// the next sample only after that write-back, which waits for a free output
// register. A sample's event passes through the queue, the read-cycle
// registers and the output register; a full queue and receiver stalls delay
// it. The per-key state is cleared by reset, with no clearing pass.
// Registers sit at byte addresses 4*i on the APB port.
module keypad_key_event_detector import kked_pkg::*; #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Sample stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // row[1:0], column[3:2], raw_level[4], key_code[12:5], time_ms[44:13], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // Event stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // key_code[7:0], click_total[10:8], zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // event_kind[1:0]
    output logic [KIND_W-1:0]   m_tuser,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    kked_cfg_t  cfg_reg;
    logic       cfg_we;
    reg_idx_t   reg_sel;

    logic       q_ready;
    logic       q_push;
    kked_item_t push_item;
    logic       q_valid;
    logic       q_pop;
    kked_item_t pop_item;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[4:2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce   <= DEBOUNCE_RST;
            cfg_reg.click_min  <= CLICK_MIN_RST;
            cfg_reg.click_max  <= CLICK_MAX_RST;
            cfg_reg.gap        <= GAP_RST;
            cfg_reg.keepalive  <= KEEPALIVE_RST;
            cfg_reg.max_clicks <= MAX_CLICKS_RST;
            cfg_reg.no_rows    <= NO_ROWS_RST;
        end else if (cfg_we) begin
            case (reg_sel)
                REG_DEBOUNCE:   cfg_reg.debounce   <= pwdata[CFG_W-1:0];
                REG_CLICK_MIN:  cfg_reg.click_min  <= pwdata[CFG_W-1:0];
                REG_CLICK_MAX:  cfg_reg.click_max  <= pwdata[CFG_W-1:0];
                REG_GAP:        cfg_reg.gap        <= pwdata[CFG_W-1:0];
                REG_KEEPALIVE:  cfg_reg.keepalive  <= pwdata[CFG_W-1:0];
                REG_MAX_CLICKS: cfg_reg.max_clicks <= pwdata[CNT_W-1:0];
                REG_NO_ROWS:    cfg_reg.no_rows    <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_sel)
            REG_DEBOUNCE:   prdata = {16'd0, cfg_reg.debounce};
            REG_CLICK_MIN:  prdata = {16'd0, cfg_reg.click_min};
            REG_CLICK_MAX:  prdata = {16'd0, cfg_reg.click_max};
            REG_GAP:        prdata = {16'd0, cfg_reg.gap};
            REG_KEEPALIVE:  prdata = {16'd0, cfg_reg.keepalive};
            REG_MAX_CLICKS: prdata = {29'd0, cfg_reg.max_clicks};
            REG_NO_ROWS:    prdata = {28'd0, cfg_reg.no_rows};
            default:        prdata = '0;
        endcase
    end

    kked_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .no_rows  (cfg_reg.no_rows),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    kked_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    kked_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/kked_front.sv =====
// Front end: takes samples, drops off-keypad positions, applies row polarity.
`timescale 1ns / 1ps

module kked_front import kked_pkg::*; #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
) (
    input  logic                s_tvalid,
    output logic                s_tready,
    // row[1:0], column[3:2], raw_level[4], key_code[12:5], time_ms[44:13], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [MASK_W-1:0]   no_rows,
    input  logic                q_ready,
    output logic                q_push,
    output kked_item_t          q_item
);

    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              raw;
    logic              in_range;
    logic              row_no;

    // Unpack the sample
    assign row = s_tdata[1:0];
    assign col = s_tdata[3:2];
    assign raw = s_tdata[4];

    // Positions outside the keypad are taken and dropped
    assign in_range = (int'(row) < ROWS) && (int'(col) < COLUMNS);
    assign row_no   = no_rows[row];

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && in_range;

    // Normally-closed rows read inverted
    always_comb begin
        q_item.row   = row;
        q_item.col   = col;
        q_item.level = row_no ? raw : ~raw;
        q_item.code  = s_tdata[12:5];
        q_item.now   = s_tdata[44:13];
    end

endmodule

// ===== rtl/kked_queue.sv =====
// Short register queue that decouples the front end from the state engine.
`timescale 1ns / 1ps

module kked_queue import kked_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  kked_item_t push_item,
    output logic       not_full,
    input  logic       pop,
    output logic       not_empty,
    output kked_item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    kked_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;

    assign not_full  = (count_reg != CNT_QW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // Pointer wrap
    always_comb begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/kked_back.sv =====
// State engine: per-key read-modify-write and event generation, output register.
`timescale 1ns / 1ps

module kked_back import kked_pkg::*; #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kked_cfg_t           cfg,
    input  logic                q_valid,
    input  kked_item_t          q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    // key_code[7:0], click_total[10:8], zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // event_kind[1:0]
    output logic [KIND_W-1:0]   m_tuser
);

    // Only positions a 2-bit row/column can reach hold state
    localparam int KEY_ROWS = (ROWS < 4) ? ROWS : 4;
    localparam int KEY_COLS = (COLUMNS < 4) ? COLUMNS : 4;
    localparam int NKEYS    = KEY_ROWS * KEY_COLS;
    localparam int KIDX_W   = (NKEYS > 1) ? $clog2(NKEYS) : 1;

    // Per-key state
    logic              prev_level_reg  [NKEYS];
    logic              press_sent_reg  [NKEYS];
    logic [TIME_W-1:0] change_time_reg [NKEYS];
    logic [TIME_W-1:0] hold_time_reg   [NKEYS];
    logic [CNT_W-1:0]  click_count_reg [NKEYS];
    logic [TIME_W-1:0] click_time_reg  [NKEYS];

    bk_phase_t         phase_reg;
    bk_phase_t         phase_next;

    // Values latched in the read cycle
    kked_item_t        cur_reg;
    logic [KIDX_W-1:0] idx_reg;
    logic              prev_rd_reg;
    logic              sent_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;
    logic [TIME_W-1:0] d_change_reg;
    logic [TIME_W-1:0] d_hold_reg;
    logic [TIME_W-1:0] d_click_reg;
    logic [TIME_W-1:0] hold_sum_reg;

    // Output register
    logic                m_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [CODE_W-1:0]   code_out_reg;
    logic [CNT_W-1:0]    total_reg;

    logic              out_free;
    logic              commit;
    logic [KIDX_W-1:0] rd_idx;

    // Evaluation results
    logic              emit;
    event_kind_t       emit_kind;
    logic [CNT_W-1:0]  emit_total;
    logic              sent_new;
    logic [CNT_W-1:0]  cnt_new;
    logic              wr_change;
    logic              wr_hold;
    logic [TIME_W-1:0] hold_new;
    logic              wr_click_time;
    logic              is_click;
    logic              chain;

    assign rd_idx   = KIDX_W'(int'(q_item.row) * KEY_COLS + int'(q_item.col));
    assign out_free = !m_valid_reg || m_tready;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            BK_READ: begin
                if (q_valid) begin
                    phase_next = BK_EVAL;
                end
            end
            BK_EVAL: begin
                if (out_free) begin
                    phase_next = BK_READ;
                end
            end
            default: phase_next = BK_READ;
        endcase
    end

    // Phase outputs
    always_comb begin
        q_pop  = 1'b0;
        commit = 1'b0;
        case (phase_reg)
            BK_READ: q_pop  = q_valid;
            BK_EVAL: commit = out_free;
            default: begin
                q_pop  = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= BK_READ;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Read cycle: fetch the key's state and form the time differences
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg      <= q_item;
            idx_reg      <= rd_idx;
            prev_rd_reg  <= prev_level_reg[rd_idx];
            sent_rd_reg  <= press_sent_reg[rd_idx];
            cnt_rd_reg   <= click_count_reg[rd_idx];
            d_change_reg <= q_item.now - change_time_reg[rd_idx];
            d_hold_reg   <= q_item.now - hold_time_reg[rd_idx];
            d_click_reg  <= q_item.now - click_time_reg[rd_idx];
            hold_sum_reg <= hold_time_reg[rd_idx] + TIME_W'(cfg.keepalive);
        end
    end

    // Evaluate cycle: decide the event and the state update
    always_comb begin
        emit          = 1'b0;
        emit_kind     = EV_PRESSED;
        emit_total    = cnt_rd_reg;
        sent_new      = sent_rd_reg;
        cnt_new       = cnt_rd_reg;
        wr_change     = 1'b0;
        wr_hold       = 1'b0;
        hold_new      = cur_reg.now;
        wr_click_time = 1'b0;
        is_click      = (d_change_reg >= TIME_W'(cfg.click_min))
                        && (d_change_reg <= TIME_W'(cfg.click_max));
        chain         = (cnt_rd_reg != '0) && (cnt_rd_reg < cfg.max_clicks)
                        && (d_click_reg < TIME_W'(cfg.gap));
        if (cur_reg.level != prev_rd_reg) begin
            // Level changed: restart timing, report a release if pressed
            wr_change = 1'b1;
            wr_hold   = 1'b1;
            if (!cur_reg.level && sent_rd_reg) begin
                sent_new = 1'b0;
                if (is_click) begin
                    cnt_new       = chain ? cnt_rd_reg + 1'b1 : CNT_W'(1);
                    wr_click_time = 1'b1;
                end
                emit       = 1'b1;
                emit_kind  = EV_RELEASED;
                emit_total = cnt_new;
            end
        end else if (cur_reg.level) begin
            // Held: debounce, then keep-alive
            if (!sent_rd_reg) begin
                if (d_change_reg >= TIME_W'(cfg.debounce)) begin
                    sent_new  = 1'b1;
                    wr_hold   = 1'b1;
                    emit      = 1'b1;
                    emit_kind = EV_PRESSED;
                end
            end else if (d_hold_reg >= TIME_W'(cfg.keepalive)) begin
                wr_hold   = 1'b1;
                hold_new  = hold_sum_reg;
                emit      = 1'b1;
                emit_kind = EV_HOLD;
            end
        end else begin
            // Released and idle: close the click series after the gap
            if ((cnt_rd_reg != '0) && (d_click_reg >= TIME_W'(cfg.gap))) begin
                emit      = 1'b1;
                emit_kind = EV_CLICKED;
                cnt_new   = '0;
            end
        end
    end

    // Per-key state write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NKEYS; k++) begin
                prev_level_reg[k]  <= 1'b0;
                press_sent_reg[k]  <= 1'b0;
                change_time_reg[k] <= '0;
                hold_time_reg[k]   <= '0;
                click_count_reg[k] <= '0;
                click_time_reg[k]  <= '0;
            end
        end else if (commit) begin
            prev_level_reg[idx_reg]  <= cur_reg.level;
            press_sent_reg[idx_reg]  <= sent_new;
            click_count_reg[idx_reg] <= cnt_new;
            if (wr_change) begin
                change_time_reg[idx_reg] <= cur_reg.now;
            end
            if (wr_hold) begin
                hold_time_reg[idx_reg] <= hold_new;
            end
            if (wr_click_time) begin
                click_time_reg[idx_reg] <= cur_reg.now;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && emit) begin
            kind_reg     <= emit_kind;
            code_out_reg <= cur_reg.code;
            total_reg    <= emit_total;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {{(M_DATA_W - CODE_W - CNT_W){1'b0}}, total_reg, code_out_reg};

    // A press is only ever marked sent on a key whose level is high
    a_sent_implies_level: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == BK_EVAL |-> !sent_rd_reg || prev_rd_reg)
        else $error("press-sent flag set on a released key");

    // An idle read cycle stays idle
    a_idle_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == BK_READ && !q_valid) |=> phase_reg == BK_READ)
        else $error("state engine left read phase without an item");

    // New results come only out of an evaluate cycle
    a_load_from_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> $past(phase_reg == BK_EVAL))
        else $error("result loaded outside evaluate phase");

    // A stalled result is never overwritten by a commit
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !commit)
        else $error("commit while result register is blocked");

endmodule

// ===== tb/tb_keypad_key_event_detector.sv =====
// Self-checking testbench for the keypad key event detector.
`timescale 1ns / 1ps

module tb_keypad_key_event_detector;
    import kked_pkg::*;

    localparam int KP_ROWS      = 4;
    localparam int KP_COLS      = 4;
    localparam int KP_KEYS      = KP_ROWS * KP_COLS;
    localparam int SETTLE_CYC   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 320;

    // One event as it leaves the block
    typedef struct packed {
        event_kind_t       kind;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  clicks;
    } key_event_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [4:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    keypad_key_event_detector #(
        .ROWS    (KP_ROWS),
        .COLUMNS (KP_COLS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Mirror of the configuration registers
    logic [CFG_W-1:0]  cfg_debounce   = DEBOUNCE_RST;
    logic [CFG_W-1:0]  cfg_click_min  = CLICK_MIN_RST;
    logic [CFG_W-1:0]  cfg_click_max  = CLICK_MAX_RST;
    logic [CFG_W-1:0]  cfg_gap        = GAP_RST;
    logic [CFG_W-1:0]  cfg_keepalive  = KEEPALIVE_RST;
    logic [CNT_W-1:0]  cfg_max_clicks = MAX_CLICKS_RST;
    logic [MASK_W-1:0] cfg_no_rows    = NO_ROWS_RST;

    // Mirror of the per-key state
    logic              key_level [KP_KEYS];
    logic              key_sent  [KP_KEYS];
    logic [TIME_W-1:0] key_change[KP_KEYS];
    logic [TIME_W-1:0] hold_stamp[KP_KEYS];
    logic [CNT_W-1:0]  key_clicks[KP_KEYS];
    logic [TIME_W-1:0] key_click_t[KP_KEYS];

    logic [S_DATA_W-1:0] pending_q[$];
    key_event_t          event_q[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int err_count      = 0;
    int samples_sent   = 0;
    int events_seen    = 0;
    int settings_run   = 0;
    int cycle_cnt      = 0;
    int step_max       = 100;
    logic [TIME_W-1:0] t_now = '0;
    key_event_t mon_ev;

    initial begin
        for (int i = 0; i < KP_KEYS; i++) begin
            key_level[i]   = 1'b0;
            key_sent[i]    = 1'b0;
            key_change[i]  = '0;
            hold_stamp[i]  = '0;
            key_clicks[i]  = '0;
            key_click_t[i] = '0;
        end
    end

    // Debounce / hold / click tracking for one accepted sample
    function automatic void track_sample(input logic [S_DATA_W-1:0] d);
        logic [POS_W-1:0]  r;
        logic [POS_W-1:0]  c;
        logic              lvl;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] dt;
        int                k;
        key_event_t        ev;
        bit                hit;
        r    = d[1:0];
        c    = d[3:2];
        code = d[12:5];
        now  = d[44:13];
        k    = r * KP_COLS + c;
        lvl  = cfg_no_rows[r] ? d[4] : ~d[4];
        hit  = 1'b0;
        if (lvl != key_level[k]) begin
            // edge: release may close a click
            if (!lvl && key_sent[k]) begin
                key_sent[k] = 1'b0;
                dt = now - key_change[k];
                if (dt >= cfg_click_min && dt <= cfg_click_max) begin
                    if (key_clicks[k] != 0 && key_clicks[k] < cfg_max_clicks &&
                        (now - key_click_t[k]) < cfg_gap)
                        key_clicks[k] = key_clicks[k] + 1'b1;
                    else
                        key_clicks[k] = 3'd1;
                    key_click_t[k] = now;
                end
                ev  = '{EV_RELEASED, code, key_clicks[k]};
                hit = 1'b1;
            end
            key_change[k] = now;
            hold_stamp[k] = now;
        end else if (lvl) begin
            if (!key_sent[k]) begin
                if ((now - key_change[k]) >= cfg_debounce) begin
                    key_sent[k]   = 1'b1;
                    hold_stamp[k] = now;
                    ev  = '{EV_PRESSED, code, key_clicks[k]};
                    hit = 1'b1;
                end
            end else if ((now - hold_stamp[k]) >= cfg_keepalive) begin
                hold_stamp[k] = hold_stamp[k] + cfg_keepalive;
                ev  = '{EV_HOLD, code, key_clicks[k]};
                hit = 1'b1;
            end
        end else begin
            // steady released: report a finished click series
            if (key_clicks[k] != 0 && (now - key_click_t[k]) >= cfg_gap) begin
                ev  = '{EV_CLICKED, code, key_clicks[k]};
                key_clicks[k] = '0;
                hit = 1'b1;
            end
        end
        key_level[k] = lvl;
        if (hit)
            event_q.push_back(ev);
    endfunction

    // Sample driver: one transfer per handshake, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_sample(s_tdata);
                samples_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= pending_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Event monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            events_seen++;
            if (event_q.size() == 0) begin
                $error("unexpected event: kind %0d code %0h clicks %0d",
                       m_tuser, m_tdata[7:0], m_tdata[10:8]);
                err_count++;
            end else begin
                mon_ev = event_q.pop_front();
                if (mon_ev.kind !== event_kind_t'(m_tuser)) begin
                    $error("event_kind: expected %0d, actual %0d", mon_ev.kind, m_tuser);
                    err_count++;
                end
                if (mon_ev.code !== m_tdata[7:0]) begin
                    $error("event_key_code: expected %0h, actual %0h",
                           mon_ev.code, m_tdata[7:0]);
                    err_count++;
                end
                if (mon_ev.clicks !== m_tdata[10:8]) begin
                    $error("click_total: expected %0d, actual %0d",
                           mon_ev.clicks, m_tdata[10:8]);
                    err_count++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] reg_value(input reg_idx_t idx);
        case (idx)
            REG_DEBOUNCE:   return {16'd0, cfg_debounce};
            REG_CLICK_MIN:  return {16'd0, cfg_click_min};
            REG_CLICK_MAX:  return {16'd0, cfg_click_max};
            REG_GAP:        return {16'd0, cfg_gap};
            REG_KEEPALIVE:  return {16'd0, cfg_keepalive};
            REG_MAX_CLICKS: return {29'd0, cfg_max_clicks};
            default:        return {28'd0, cfg_no_rows};
        endcase
    endfunction

    // APB write, then read back the same register
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        logic [31:0] rd;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DEBOUNCE:   cfg_debounce   = val[15:0];
            REG_CLICK_MIN:  cfg_click_min  = val[15:0];
            REG_CLICK_MAX:  cfg_click_max  = val[15:0];
            REG_GAP:        cfg_gap        = val[15:0];
            REG_KEEPALIVE:  cfg_keepalive  = val[15:0];
            REG_MAX_CLICKS: cfg_max_clicks = val[2:0];
            default:        cfg_no_rows    = val[3:0];
        endcase
        @(posedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== reg_value(idx)) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, reg_value(idx), rd);
            err_count++;
        end
    endtask

    // Wait until the block has drained every sample
    task automatic wait_idle();
        while (pending_q.size() != 0 || s_tvalid || event_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic push_sample(input int k, input logic raw, input logic [7:0] code,
                               input logic [31:0] t);
        pending_q.push_back({3'b000, t, code, raw, 2'(k % KP_COLS), 2'(k / KP_COLS)});
    endtask

    // Physical key level, converted to the pin level for the row's polarity
    task automatic push_level(input int k, input logic lvl);
        logic raw;
        raw = cfg_no_rows[k / KP_COLS] ? lvl : ~lvl;
        t_now = t_now + 32'($urandom_range(0, step_max));
        push_sample(k, raw, 8'($urandom_range(0, 255)), t_now);
    endtask

    // Press series on random keys, with bounces and noise samples
    task automatic gen_traffic(input int n_items);
        int made;
        int k;
        int series;
        int presses;
        int rels;
        made = 0;
        while (made < n_items) begin
            k = $urandom_range(0, KP_KEYS - 1);
            series = $urandom_range(1, 4);
            for (int i = 0; i < series; i++) begin
                case ($urandom_range(0, 9))
                    0, 1:    presses = $urandom_range(12, 40);
                    2:       presses = 1;
                    default: presses = $urandom_range(2, 5);
                endcase
                for (int j = 0; j < presses; j++) begin
                    push_level(k, ($urandom_range(0, 19) == 0) ? 1'b0 : 1'b1);
                    made++;
                end
                rels = $urandom_range(1, 3);
                for (int j = 0; j < rels; j++) begin
                    push_level(k, 1'b0);
                    made++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    push_sample($urandom_range(0, KP_KEYS - 1), 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)), $urandom);
                    made++;
                end
            end
            // long quiet time so the series gets reported
            t_now = t_now + 32'(step_max * $urandom_range(2, 6));
            push_level(k, 1'b0);
            made++;
        end
    endtask

    task automatic run_setting(input logic [15:0] deb, input logic [15:0] cmin,
                               input logic [15:0] cmax, input logic [15:0] gap,
                               input logic [15:0] keep, input logic [2:0] mc,
                               input logic [3:0] no_mask, input logic [31:0] t0);
        int m;
        wait_idle();
        write_reg(REG_DEBOUNCE, {16'd0, deb});
        write_reg(REG_CLICK_MIN, {16'd0, cmin});
        write_reg(REG_CLICK_MAX, {16'd0, cmax});
        write_reg(REG_GAP, {16'd0, gap});
        write_reg(REG_KEEPALIVE, {16'd0, keep});
        write_reg(REG_MAX_CLICKS, {29'd0, mc});
        write_reg(REG_NO_ROWS, {28'd0, no_mask});
        settings_run++;
        m = deb;
        if (cmax > m) m = cmax;
        if (gap > m) m = gap;
        step_max = m / 3 + 1;
        t_now = t0;
        gen_traffic(PHASE_ITEMS / 2);
        // hold the sender until every event has come back
        wait_idle();
        gen_traffic(PHASE_ITEMS / 2);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 55;

        // Directed: reset settings, all rows normally open
        // press after debounce, one hold, long release
        push_sample(0, 1'b1, 8'h00, 32'd0);
        push_sample(0, 1'b1, 8'h11, 32'd10);
        push_sample(0, 1'b1, 8'h22, 32'd20);
        push_sample(0, 1'b1, 8'h33, 32'd1020);
        push_sample(0, 1'b0, 8'h44, 32'd1100);
        // four clicks: count runs to the maximum and restarts at one
        for (int i = 0; i < 4; i++) begin
            push_sample(5, 1'b1, 8'h50, 32'(2000 + 150 * i));
            push_sample(5, 1'b1, 8'h51, 32'(2030 + 150 * i));
            push_sample(5, 1'b0, 8'h52, 32'(2100 + 150 * i));
        end
        push_sample(5, 1'b0, 8'h53, 32'd3000);
        // release before any press was sent
        push_sample(15, 1'b1, 8'h60, 32'd5000);
        push_sample(15, 1'b0, 8'h61, 32'd5005);
        // press across the time wrap, extreme code and time values
        push_sample(10, 1'b1, 8'hFF, 32'hFFFF_FFF0);
        push_sample(10, 1'b1, 8'hFF, 32'h0000_0008);
        push_sample(10, 1'b0, 8'h00, 32'h0000_000F);
        push_sample(3, 1'b0, 8'hFF, 32'hFFFF_FFFF);
        push_sample(12, 1'b1, 8'h7E, 32'hFFFF_FFFF);
        push_sample(12, 1'b1, 8'h81, 32'h0000_0000);

        run_setting(16'd20, 16'd20, 16'd300, 16'd400, 16'd1000, 3'd3, 4'hF, $urandom);
        // zero keep-alive and zero max clicks, widest click window
        run_setting(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 3'd0, 4'h0, 32'hFFFF_0000);

        send_idle_pct = 55;
        recv_idle_pct = 25;
        run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 3'd7, 4'hA, $urandom);
        run_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 3'($urandom), 4'($urandom), $urandom);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(16'd5, 16'd10, 16'd80, 16'd120, 16'd50, 3'd7, 4'h5, $urandom);
        run_setting(16'($urandom_range(0, 200)), 16'($urandom_range(0, 100)),
                    16'($urandom_range(100, 600)), 16'($urandom_range(0, 800)),
                    16'($urandom_range(0, 300)), 3'($urandom), 4'($urandom), $urandom);

        wait_idle();
        $display("Covered %0d samples and %0d events over %0d register settings,",
                 samples_sent, events_seen, settings_run);
        $display("with sender and receiver stalls, polarity masks and time wrap.");
        if (err_count == 0 && event_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
